// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL modules. Each macro samples on the
// rising edge of clk and is disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled edge.
`define MVM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition must never be true at a sampled edge.
`define MVM_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/core/mvm_pkg.sv =====
// ---------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants of the matrix-vector multiplier.
// ---------------------------------------------------------------------------
package mvm_pkg;

  // Field widths fixed by the interface
  localparam int unsigned ELEM_W         = 32;
  localparam int unsigned INDEX_W        = 4;
  localparam int unsigned RESULT_INDEX_W = 4;
  localparam int unsigned CFG_INDEX_W    = 2;
  localparam int unsigned CFG_DATA_W     = 5;
  localparam int unsigned DIM_REG_W      = 5;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COL_COUNT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PRODUCT_MODE = 2'd2;

  // Input commands
  localparam logic CMD_MATRIX_WRITE  = 1'b0;
  localparam logic CMD_VECTOR_APPEND = 1'b1;

  // Product modes
  localparam logic MODE_MAT_VEC = 1'b0;
  localparam logic MODE_VEC_MAT = 1'b1;

  // Result status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_MISMATCH = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_RND,
    ST_SAT,
    ST_OUT
  } mvm_state_t;

endpackage

// ===== rtl/core/mvm_ram.sv =====
// ---------------------------------------------------------------------------
// mvm_ram
// Generic single-clock RAM, one write port and one read port, with the
// read data registered.
// ---------------------------------------------------------------------------
module mvm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/matrix_vector_multiply_top.sv =====
// ---------------------------------------------------------------------------
// matrix_vector_multiply_top
// Dense matrix-vector multiplier in signed Q16.16. Matrix elements are
// written by row and column, vector elements stream in, and the element
// flagged last starts matrix-times-vector or vector-times-matrix on one
// shared 32x32 multiply-accumulate unit.
//
//   Channel  Handshake             Payload
//   -------  --------------------  -----------------------------------------
//   in       in_valid / in_ready   command, row/col index, element, last
//   out      out_valid / out_ready result value, index, status, saturated,
//                                  last result
//   cfg      cfg_valid / cfg_ready register index, data (always ready)
//
// Matrix writes and vector elements without the last flag are taken while
// the block is idle. The last vector element starts a product of outs
// results; each is formed by need reads through the one MAC, a drain
// through read, multiply and accumulate, then rounding, saturation and the
// result transaction. A length mismatch gives one error result, valid in
// the cycle after acceptance.
// in_ready is low from the last vector element until the final result is
// taken; reset is synchronous and the stores are not cleared.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix_vector_multiply_top #(
  parameter int unsigned MAX_DIM   = 16,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_command,
  input  logic [mvm_pkg::INDEX_W-1:0]          in_row_index,
  input  logic [mvm_pkg::INDEX_W-1:0]          in_col_index,
  input  logic signed [mvm_pkg::ELEM_W-1:0]    in_element_value,
  input  logic                                 in_vector_last,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mvm_pkg::ELEM_W-1:0]    out_result_value,
  output logic [mvm_pkg::RESULT_INDEX_W-1:0]   out_result_index,
  output logic                                 out_status,
  output logic                                 out_saturated,
  output logic                                 out_last_result,
  // configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mvm_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [mvm_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import mvm_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_DIM + 1);
  localparam int unsigned CNTW  = $clog2(MAX_DIM + 2);
  localparam int unsigned VW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int unsigned PROD_W = 2 * ELEM_W;
  localparam int unsigned ACC_W = PROD_W + $clog2(MAX_DIM + 1) + 1;
  localparam logic [ACC_W-1:0] RND_HALF = (ACC_W'(1) << FRAC_BITS) >> 1;
  localparam logic [ELEM_W-1:0] SAT_POS = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] SAT_NEG = {1'b1, {(ELEM_W-1){1'b0}}};

  mvm_state_t state_r, state_nxt;

  logic [DIM_REG_W-1:0] row_count_r, col_count_r;
  logic                 product_mode_r;
  logic [CNTW-1:0]      vec_cnt_r, vec_cnt_inc;
  logic [CW-1:0]        i_r, j_r;
  logic [CW-1:0]        rows, cols, need, outs;
  logic                 rd_vld_r, prod_vld_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, rnd_r, shifted;
  logic                 fits;

  logic in_acc, out_acc, vec_last_acc, mismatch;
  logic issue, mtx_we, vec_we, vec_in_range;

  logic [AW-1:0]     mtx_waddr, mtx_raddr;
  logic [ELEM_W-1:0] mtx_rdata, vec_rdata;

  logic                      out_valid_r;
  logic [ELEM_W-1:0]         out_value_r;
  logic [RESULT_INDEX_W-1:0] out_index_r;
  logic                      out_status_r, out_sat_r, out_last_r;

  // Clip configured sizes to the store
  always_comb begin
    rows = (int'(row_count_r) > MAX_DIM) ? CW'(MAX_DIM) : CW'(row_count_r);
    cols = (int'(col_count_r) > MAX_DIM) ? CW'(MAX_DIM) : CW'(col_count_r);
    need = (product_mode_r == MODE_VEC_MAT) ? rows : cols;
    outs = (product_mode_r == MODE_VEC_MAT) ? cols : rows;
  end

  // Handshake events and length check
  assign in_acc       = in_valid && in_ready;
  assign out_acc      = out_valid_r && out_ready;
  assign vec_last_acc = in_acc && (in_command == CMD_VECTOR_APPEND) && in_vector_last;
  assign vec_in_range = int'(vec_cnt_r) < MAX_DIM;
  assign vec_cnt_inc  = (int'(vec_cnt_r) <= MAX_DIM) ? vec_cnt_r + 1'b1 : vec_cnt_r;
  assign mismatch     = (vec_cnt_inc != CNTW'(need)) || (need == '0) || (outs == '0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (vec_last_acc) begin
          state_nxt = mismatch ? ST_OUT : ST_MAC;
        end
      end
      ST_MAC: begin
        if ((j_r == need) && !rd_vld_r && !prod_vld_r) begin
          state_nxt = ST_RND;
        end
      end
      ST_RND: state_nxt = ST_SAT;
      ST_SAT: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = out_last_r ? ST_IDLE : ST_MAC;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    issue    = (state_r == ST_MAC) && (j_r != need);
    mtx_we   = in_acc && (in_command == CMD_MATRIX_WRITE) &&
               (int'(in_row_index) < MAX_DIM) && (int'(in_col_index) < MAX_DIM);
    vec_we   = in_acc && (in_command == CMD_VECTOR_APPEND) && vec_in_range;
  end

  // Store addresses
  assign mtx_waddr = AW'(int'(in_row_index) * MAX_DIM + int'(in_col_index));
  assign mtx_raddr = (product_mode_r == MODE_VEC_MAT) ?
                     AW'(int'(j_r) * MAX_DIM + int'(i_r)) :
                     AW'(int'(i_r) * MAX_DIM + int'(j_r));

  mvm_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (MAX_DIM * MAX_DIM)
  ) u_mtx_ram (
    .clk     (clk),
    .we      (mtx_we),
    .waddr   (mtx_waddr),
    .wdata   (in_element_value),
    .re      (issue),
    .raddr   (mtx_raddr),
    .rdata_r (mtx_rdata)
  );

  mvm_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (MAX_DIM)
  ) u_vec_ram (
    .clk     (clk),
    .we      (vec_we),
    .waddr   (vec_cnt_r[VW-1:0]),
    .wdata   (in_element_value),
    .re      (issue),
    .raddr   (j_r[VW-1:0]),
    .rdata_r (vec_rdata)
  );

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= '0;
      col_count_r    <= '0;
      product_mode_r <= MODE_MAT_VEC;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW_COUNT:    row_count_r    <= cfg_data[DIM_REG_W-1:0];
        REG_COL_COUNT:    col_count_r    <= cfg_data[DIM_REG_W-1:0];
        REG_PRODUCT_MODE: product_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vec_cnt_r   <= '0;
      rd_vld_r    <= 1'b0;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_vld_r   <= issue;
      prod_vld_r <= rd_vld_r;
      // count vector elements, drop back to zero when the product starts
      if (in_acc && (in_command == CMD_VECTOR_APPEND)) begin
        vec_cnt_r <= in_vector_last ? '0 : vec_cnt_inc;
      end
      if ((state_r == ST_SAT) || (vec_last_acc && mismatch)) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Loop indexes
  always_ff @(posedge clk) begin
    if (vec_last_acc) begin
      i_r <= '0;
      j_r <= '0;
    end else if (issue) begin
      j_r <= j_r + 1'b1;
    end else if ((state_r == ST_OUT) && out_ready && !out_last_r) begin
      i_r <= i_r + 1'b1;
      j_r <= '0;
    end
  end

  // Multiply, then accumulate
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      prod_r <= $signed(mtx_rdata) * $signed(vec_rdata);
    end
    if (vec_last_acc || ((state_r == ST_OUT) && out_ready)) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (state_r == ST_RND) begin
      rnd_r <= acc_r + $signed(RND_HALF);
    end
  end

  // Drop fraction bits and check the 32-bit range
  assign shifted = rnd_r >>> FRAC_BITS;
  assign fits    = (&shifted[ACC_W-1:ELEM_W-1]) || !(|shifted[ACC_W-1:ELEM_W-1]);

  // Load the result register
  always_ff @(posedge clk) begin
    if (vec_last_acc && mismatch) begin
      out_value_r  <= '0;
      out_index_r  <= '0;
      out_status_r <= STATUS_MISMATCH;
      out_sat_r    <= 1'b0;
      out_last_r   <= 1'b1;
    end else if (state_r == ST_SAT) begin
      out_value_r  <= fits ? shifted[ELEM_W-1:0] :
                      (shifted[ACC_W-1] ? SAT_NEG : SAT_POS);
      out_index_r  <= RESULT_INDEX_W'(i_r);
      out_status_r <= STATUS_OK;
      out_sat_r    <= !fits;
      out_last_r   <= (i_r == CW'(outs - 1'b1));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_result_index = out_index_r;
  assign out_status       = out_status_r;
  assign out_saturated    = out_sat_r;
  assign out_last_result  = out_last_r;

  // Checks
  `MVM_ASSERT_NEVER(a_ready_while_result, out_valid_r && in_ready,
                    "input taken while a result waits")
  `MVM_ASSERT(a_cnt_bound, int'(vec_cnt_r) <= MAX_DIM + 1,
              "vector count beyond saturation")
  `MVM_ASSERT(a_drain_before_round, (state_r == ST_RND) |-> (!rd_vld_r && !prod_vld_r),
              "rounding started with products in flight")
  `MVM_ASSERT(a_error_is_final,
              (out_valid_r && (out_status_r == STATUS_MISMATCH)) |-> (out_last_r && !out_sat_r),
              "error result not marked final")
  `MVM_ASSERT(a_last_returns_idle, (out_acc && out_last_r) |=> in_ready,
              "block not idle after final result")

endmodule

// ===== test/matrix_vector_multiply_top_check.sv =====
// ----------------------------------------------------------------------------
// matrix_vector_multiply_top_check
// Watches the input, result and configuration channels of the multiplier. It
// keeps a shadow copy of the matrix, the vector and the registers, works out
// every product in exact wide arithmetic with rounding and saturation, and
// compares each result transaction field by field against the oldest
// expected result.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_top_check (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 in_command,
  input  logic [mvm_pkg::INDEX_W-1:0]          in_row_index,
  input  logic [mvm_pkg::INDEX_W-1:0]          in_col_index,
  input  logic signed [mvm_pkg::ELEM_W-1:0]    in_element_value,
  input  logic                                 in_vector_last,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [mvm_pkg::ELEM_W-1:0]    out_result_value,
  input  logic [mvm_pkg::RESULT_INDEX_W-1:0]   out_result_index,
  input  logic                                 out_status,
  input  logic                                 out_saturated,
  input  logic                                 out_last_result,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [mvm_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [mvm_pkg::CFG_DATA_W-1:0]       cfg_data,
  output int                                   mismatch_count,
  output int                                   results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import mvm_pkg::*;

  localparam int DIM_LIMIT = 16;
  localparam int FRAC      = 16;
  localparam logic signed [79:0] Q_MAX  = 80'sh7FFF_FFFF;
  localparam logic signed [79:0] Q_MIN  = -80'sh8000_0000;
  localparam logic signed [79:0] Q_HALF = 80'sh8000;

  typedef struct packed {
    logic [ELEM_W-1:0]         value;
    logic [RESULT_INDEX_W-1:0] index;
    logic                      status;
    logic                      saturated;
    logic                      is_last;
  } product_result_t;

  logic signed [ELEM_W-1:0] matrix_mem [DIM_LIMIT][DIM_LIMIT];
  logic signed [ELEM_W-1:0] vector_mem [DIM_LIMIT];
  logic [4:0]               vector_len;
  logic [DIM_REG_W-1:0]     rows_reg;
  logic [DIM_REG_W-1:0]     cols_reg;
  logic                     mode_reg;
  product_result_t          results_due [$];

  initial mismatch_count = 0;
  initial results_pending = 0;

  // Round half up to the Q16.16 grid, then clip to 32 bits; bit 32 flags a clip
  function automatic logic [32:0] round_clip(input logic signed [79:0] acc);
    logic signed [79:0] rounded;
    rounded = (acc + Q_HALF) >>> FRAC;
    if (rounded > Q_MAX) return {1'b1, 32'h7FFF_FFFF};
    if (rounded < Q_MIN) return {1'b1, 32'h8000_0000};
    return {1'b0, rounded[31:0]};
  endfunction

  // Queue the results of the product started by the last vector element
  task automatic queue_product();
    int rows, cols, need, outs;
    logic signed [79:0]       acc;
    logic signed [63:0]       term;
    logic signed [ELEM_W-1:0] coeff;
    logic [32:0]              fin;
    product_result_t          res;
    rows = (rows_reg > DIM_LIMIT) ? DIM_LIMIT : rows_reg;
    cols = (cols_reg > DIM_LIMIT) ? DIM_LIMIT : cols_reg;
    need = (mode_reg == MODE_VEC_MAT) ? rows : cols;
    outs = (mode_reg == MODE_VEC_MAT) ? cols : rows;
    if (vector_len != need || need == 0 || outs == 0) begin
      res = '{value: '0, index: '0, status: STATUS_MISMATCH, saturated: 1'b0,
              is_last: 1'b1};
      results_due.push_back(res);
    end else begin
      for (int i = 0; i < outs; i++) begin
        acc = '0;
        for (int j = 0; j < need; j++) begin
          coeff = (mode_reg == MODE_VEC_MAT) ? matrix_mem[j][i] : matrix_mem[i][j];
          term  = coeff * vector_mem[j];
          acc   = acc + term;
        end
        fin = round_clip(acc);
        res = '{value: fin[31:0], index: i[RESULT_INDEX_W-1:0], status: STATUS_OK,
                saturated: fin[32], is_last: (i == outs - 1)};
        results_due.push_back(res);
      end
    end
    vector_len = '0;
  endtask

  // Report one field that differs and return whether it matched
  function automatic bit field_ok(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
    if (want === got) return 1'b1;
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    product_result_t exp_res;
    bit              ok;
    if (!rst_n) begin
      vector_len = '0;
      rows_reg   = '0;
      cols_reg   = '0;
      mode_reg   = MODE_MAT_VEC;
      results_due.delete();
    end else begin
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW_COUNT:    rows_reg = cfg_data;
          REG_COL_COUNT:    cols_reg = cfg_data;
          REG_PRODUCT_MODE: mode_reg = cfg_data[0];
          default: ;
        endcase
      end

      // Compare each result transaction with the oldest expectation
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual value %0h index %0d status %0b",
                   $time, out_result_value, out_result_index, out_status);
          mismatch_count++;
        end else begin
          exp_res = results_due.pop_front();
          ok = field_ok("result_value", exp_res.value, out_result_value)
             & field_ok("result_index", exp_res.index, out_result_index)
             & field_ok("status", exp_res.status, out_status)
             & field_ok("saturated", exp_res.saturated, out_saturated)
             & field_ok("last_result", exp_res.is_last, out_last_result);
          if (!ok) mismatch_count++;
        end
      end

      // Apply each input transaction to the shadow state
      if (in_valid && in_ready) begin
        if (in_command == CMD_MATRIX_WRITE) begin
          matrix_mem[in_row_index][in_col_index] = in_element_value;
        end else begin
          if (vector_len < DIM_LIMIT) vector_mem[vector_len[3:0]] = in_element_value;
          if (vector_len <= DIM_LIMIT) vector_len = vector_len + 5'd1;
          if (in_vector_last) queue_product();
        end
      end
    end
    results_pending = results_due.size();
  end

endmodule

// ===== test/matrix_vector_multiply_top_test.sv =====
// ----------------------------------------------------------------------------
// matrix_vector_multiply_top_test
// Drives matrix writes, vector streams and register writes into the
// multiplier: a directed opening on saturation, rounding ties, writes during a
// vector and length errors, then random shapes and products under three
// handshake idle patterns. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mvm_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam int DIM_LIMIT   = 16;
  localparam int ITEM_TARGET = 440;
  localparam int CFG_GAP     = 8;
  localparam int END_GAP     = 32;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic                          in_command;
  logic [INDEX_W-1:0]            in_row_index;
  logic [INDEX_W-1:0]            in_col_index;
  logic signed [ELEM_W-1:0]      in_element_value;
  logic                          in_vector_last;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [ELEM_W-1:0]      out_result_value;
  logic [RESULT_INDEX_W-1:0]     out_result_index;
  logic                          out_status;
  logic                          out_saturated;
  logic                          out_last_result;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_INDEX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_data;
  int                            mismatch_count;
  int                            results_pending;

  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  int rows_eff;
  int cols_eff;
  bit vec_mat;
  bit seeded [DIM_LIMIT][DIM_LIMIT];

  matrix_vector_multiply_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_element_value (in_element_value),
    .in_vector_last   (in_vector_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_result_index (out_result_index),
    .out_status       (out_status),
    .out_saturated    (out_saturated),
    .out_last_result  (out_last_result),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  matrix_vector_multiply_top_check mvm_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_element_value (in_element_value),
    .in_vector_last   (in_vector_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_result_index (out_result_index),
    .out_status       (out_status),
    .out_saturated    (out_saturated),
    .out_last_result  (out_last_result),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .results_pending  (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result channel at random on each falling edge
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Bound the run
  initial begin
    #5_000_000;
    $display("matrix_vector_multiply_top regression: fail");
    $finish;
  end

  // Mostly small Q16.16 values, with extremes and full-range words mixed in
  function automatic logic [31:0] rand_elem();
    int pick;
    pick = $urandom_range(9);
    case (pick)
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom();
      default: return 32'($urandom_range(262143)) - 32'd131072;
    endcase
  endfunction

  // Present one input transaction and hold it until accepted
  task automatic send_item(input logic cmd, input logic [INDEX_W-1:0] row,
                           input logic [INDEX_W-1:0] col, input logic [31:0] value,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    in_command       = cmd;
    in_row_index     = row;
    in_col_index     = col;
    in_element_value = value;
    in_vector_last   = last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
    if (cmd == CMD_MATRIX_WRITE) seeded[row][col] = 1'b1;
  endtask

  // Write one register through the configuration channel
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drop valid and wait for every expected result plus some quiet cycles
  task automatic settle(input int gap);
    in_valid = 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (gap) @(negedge clk);
  endtask

  // Change the matrix shape and mode once the block has drained
  task automatic set_shape(input logic [4:0] rows, input logic [4:0] cols,
                           input logic [4:0] mode_data);
    settle(CFG_GAP);
    if ($urandom_range(7) == 0) write_reg(REG_SPARE, 5'($urandom_range(31)));
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COL_COUNT, cols);
    write_reg(REG_PRODUCT_MODE, mode_data);
    rows_eff = (rows > DIM_LIMIT) ? DIM_LIMIT : rows;
    cols_eff = (cols > DIM_LIMIT) ? DIM_LIMIT : cols;
    vec_mat  = (mode_data[0] == MODE_VEC_MAT);
  endtask

  // Write any entry of the active region that has never been written
  task automatic seed_region();
    for (int r = 0; r < rows_eff; r++)
      for (int c = 0; c < cols_eff; c++)
        if (!seeded[r][c])
          send_item(CMD_MATRIX_WRITE, r[3:0], c[3:0], rand_elem(), 1'($urandom_range(1)));
  endtask

  // Stream a vector, optionally with matrix writes slipped in between elements
  task automatic stream_vector(input int len, input bit meddle);
    for (int i = 0; i < len; i++) begin
      if (meddle && $urandom_range(3) == 0)
        send_item(CMD_MATRIX_WRITE, 4'($urandom_range(15)), 4'($urandom_range(15)),
                  rand_elem(), 1'($urandom_range(1)));
      send_item(CMD_VECTOR_APPEND, 4'($urandom_range(15)), 4'($urandom_range(15)),
                rand_elem(), i == len - 1);
    end
  endtask

  // One product on the current shape: mostly well formed, some bad lengths
  task automatic run_random_product();
    int need, outs, kind, len;
    need = vec_mat ? rows_eff : cols_eff;
    outs = vec_mat ? cols_eff : rows_eff;
    kind = $urandom_range(19);
    seed_region();
    if (kind < 15 && need > 0 && outs > 0) len = need;
    else if (kind < 18) len = $urandom_range(need + 3, 1);
    else len = $urandom_range(DIM_LIMIT + 3, DIM_LIMIT + 1);
    if ($urandom_range(9) == 0)
      send_item(CMD_MATRIX_WRITE, 4'($urandom_range(15)), 4'($urandom_range(15)),
                rand_elem(), 1'b1);
    stream_vector(len, kind < 5);
  endtask

  initial begin
    int          base;
    int          done;
    int          sel;
    bit          full_done;
    logic [4:0]  r;
    logic [4:0]  c;

    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_command       = CMD_MATRIX_WRITE;
    in_row_index     = '0;
    in_col_index     = '0;
    in_element_value = '0;
    in_vector_last   = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = REG_ROW_COUNT;
    cfg_data         = '0;
    send_idle_pct    = 8;
    recv_idle_pct    = 72;
    items_sent       = 0;
    full_done        = 1'b0;
    rows_eff         = 0;
    cols_eff         = 0;
    vec_mat          = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Saturation both ways; last flag on matrix writes; write outside the size
    set_shape(5'd2, 5'd2, {4'd0, MODE_MAT_VEC});
    send_item(CMD_MATRIX_WRITE, 4'd0, 4'd0, 32'h7FFF_FFFF, 1'b0);
    send_item(CMD_MATRIX_WRITE, 4'd0, 4'd1, 32'h7FFF_FFFF, 1'b0);
    send_item(CMD_MATRIX_WRITE, 4'd1, 4'd0, 32'h8000_0000, 1'b1);
    send_item(CMD_MATRIX_WRITE, 4'd1, 4'd1, 32'h0000_8000, 1'b0);
    send_item(CMD_MATRIX_WRITE, 4'd15, 4'd15, 32'h8000_0000, 1'b1);
    send_item(CMD_VECTOR_APPEND, 4'd15, 4'd0, 32'h7FFF_FFFF, 1'b0);
    send_item(CMD_VECTOR_APPEND, 4'd0, 4'd15, 32'h7FFF_FFFF, 1'b1);

    // Rounding ties in vector-times-matrix, with a write during the vector
    set_shape(5'd2, 5'd2, {4'd0, MODE_VEC_MAT});
    send_item(CMD_MATRIX_WRITE, 4'd0, 4'd0, 32'h0000_0001, 1'b0);
    send_item(CMD_MATRIX_WRITE, 4'd0, 4'd1, 32'hFFFF_FFFF, 1'b0);
    send_item(CMD_MATRIX_WRITE, 4'd1, 4'd0, 32'h0000_0000, 1'b0);
    send_item(CMD_MATRIX_WRITE, 4'd1, 4'd1, 32'h0000_0000, 1'b0);
    send_item(CMD_VECTOR_APPEND, 4'd0, 4'd0, 32'h0000_8000, 1'b0);
    send_item(CMD_MATRIX_WRITE, 4'd1, 4'd1, 32'h0002_0000, 1'b0);
    send_item(CMD_VECTOR_APPEND, 4'd0, 4'd0, 32'h0001_0000, 1'b1);

    // Short vector, then a zero-row shape with a matching vector length
    send_item(CMD_VECTOR_APPEND, 4'd3, 4'd12, 32'h0001_0000, 1'b1);
    set_shape(5'd0, 5'd2, {4'd0, MODE_MAT_VEC});
    send_item(CMD_VECTOR_APPEND, 4'd0, 4'd0, 32'h0001_0000, 1'b0);
    send_item(CMD_VECTOR_APPEND, 4'd0, 4'd0, 32'h0001_0000, 1'b1);

    // Random shapes and products under each idle pattern in turn
    base = items_sent;
    while (items_sent - base < ITEM_TARGET) begin
      done = items_sent - base;
      if (done >= 2 * ITEM_TARGET / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (done >= ITEM_TARGET / 3) begin
        send_idle_pct = 72;
        recv_idle_pct = 8;
      end
      if (done >= 2 * ITEM_TARGET / 3 && !full_done) begin
        full_done = 1'b1;
        set_shape(5'd16, 5'd16, 5'($urandom_range(31)));
        repeat (2) run_random_product();
      end else begin
        sel = $urandom_range(19);
        case (sel)
          0: begin
            r = 5'($urandom_range(4));
            c = (r == 0) ? 5'($urandom_range(4, 1)) : 5'd0;
          end
          1: begin
            r = 5'($urandom_range(31, 16));
            c = 5'($urandom_range(3, 1));
          end
          2: begin
            r = 5'($urandom_range(3, 1));
            c = 5'($urandom_range(31, 16));
          end
          default: begin
            r = 5'($urandom_range(4, 1));
            c = 5'($urandom_range(4, 1));
          end
        endcase
        set_shape(r, c, 5'($urandom_range(31)));
        repeat ($urandom_range(3, 1)) run_random_product();
      end
    end

    settle(END_GAP);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("matrix_vector_multiply_top regression: pass");
    end else begin
      $display("matrix_vector_multiply_top regression: fail");
    end
    $finish;
  end

endmodule
